@@ sv/ccb_pkg.sv @@
`default_nettype none

package ccb_pkg;

  localparam int DEF_SURFACE_WIDTH  = 320;
  localparam int DEF_SURFACE_HEIGHT = 200;

  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPRITE_WIDTH  = 3'd0,
    CFG_SPRITE_HEIGHT = 3'd1,
    CFG_FRAME_SELECT  = 3'd2,
    CFG_DRAW_X        = 3'd3,
    CFG_DRAW_Y        = 3'd4,
    CFG_KEY_COLOR     = 3'd5
  } cfg_index_t;

  localparam logic [8:0] SPRITE_WIDTH_RESET  = 9'd16;
  localparam logic [7:0] SPRITE_HEIGHT_RESET = 8'd16;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       sheet_start;
  } pixel_item_t;

  typedef struct packed {
    logic [15:0] write_address;
    logic [7:0]  write_value;
  } write_item_t;

  typedef struct packed {
    logic [8:0]        sprite_width;
    logic [7:0]        sprite_height;
    logic [7:0]        frame_select;
    logic signed [9:0] draw_x;
    logic signed [9:0] draw_y;
    logic [7:0]        key_color;
  } cfg_t;

  // sheet position of one pixel, held in the position register ahead of the output register
  typedef struct packed {
    logic [7:0] pixel;
    logic [8:0] col;
    logic [7:0] row;
    logic [7:0] frame;
  } pos_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] address;
  } place_t;

endpackage

`default_nettype wire

@@ sv/ccb_place.sv @@
`default_nettype none

module ccb_place #(
  parameter int SURFACE_WIDTH  = ccb_pkg::DEF_SURFACE_WIDTH,
  parameter int SURFACE_HEIGHT = ccb_pkg::DEF_SURFACE_HEIGHT
) (
  input  ccb_pkg::cfg_t   cfg,
  input  ccb_pkg::pos_t   pos,
  output ccb_pkg::place_t place
);

  localparam int XW    = $clog2(SURFACE_WIDTH + 1);
  localparam int ProdW = (XW + 11 > 16) ? XW + 11 : 16;

  logic [11:0]      sx;
  logic [11:0]      sy;
  logic             x_in;
  logic             y_in;
  logic [ProdW-1:0] row_base;
  logic [ProdW-1:0] full_addr;

  assign sx = {{2{cfg.draw_x[9]}}, cfg.draw_x} + {3'b000, pos.col};
  assign sy = {{2{cfg.draw_y[9]}}, cfg.draw_y} + {4'b0000, pos.row};

  assign x_in = !sx[11] && (sx < 12'(SURFACE_WIDTH));
  assign y_in = !sy[11] && (sy < 12'(SURFACE_HEIGHT));

  // in range both coordinates are below 1024
  assign row_base  = ProdW'(sy[9:0]) * ProdW'(SURFACE_WIDTH);
  assign full_addr = row_base + ProdW'(sx[9:0]);

  assign place.hit = x_in && y_in && (pos.frame == cfg.frame_select)
                     && (pos.pixel != cfg.key_color);
  assign place.address = full_addr[15:0];

endmodule

`default_nettype wire

@@ sv/clipped_color_key_blit.sv @@
`default_nettype none

// channel   direction  handshake                 payload
// pixel     in         pixel_valid/pixel_stall   pixel_item (value, sheet start)
// write     out        write_valid/write_stall   write_item (address, value)
// cfg       in         cfg_write_enable          cfg_index, cfg_data
//
// One item per cycle sustained unless write_stall holds the output register.
// Sheet counters update as each item is accepted, placement and address
// multiply sit between the position register and the output register.
// rst (synchronous) clears counters, valids and cfg registers to their defaults.
// write_stall holds the output register; pixel_stall rises only while both
// stages are full.

module clipped_color_key_blit #(
  parameter int SURFACE_WIDTH  = ccb_pkg::DEF_SURFACE_WIDTH,
  parameter int SURFACE_HEIGHT = ccb_pkg::DEF_SURFACE_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  ccb_pkg::pixel_item_t               pixel_item,
  output logic                               write_valid,
  input  logic                               write_stall,
  output ccb_pkg::write_item_t               write_item,
  input  logic                               cfg_write_enable,
  input  logic [ccb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ccb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ccb_pkg::cfg_t   cfg;
  ccb_pkg::pos_t   pos;
  ccb_pkg::pos_t   pos_next;
  ccb_pkg::place_t place;

  logic       pos_valid;
  logic       out_ready;
  logic       accept;
  logic [8:0] column_count;
  logic [7:0] row_count;
  logic [7:0] frame_count;
  logic [8:0] column_count_next;
  logic [7:0] row_count_next;
  logic [7:0] frame_count_next;
  logic [9:0] col_inc;
  logic [8:0] row_inc;

  assign out_ready   = !write_valid || !write_stall;
  assign pixel_stall = pos_valid && !out_ready;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_width  <= ccb_pkg::SPRITE_WIDTH_RESET;
      cfg.sprite_height <= ccb_pkg::SPRITE_HEIGHT_RESET;
      cfg.frame_select  <= '0;
      cfg.draw_x        <= '0;
      cfg.draw_y        <= '0;
      cfg.key_color     <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        ccb_pkg::CFG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[8:0];
        ccb_pkg::CFG_SPRITE_HEIGHT: cfg.sprite_height <= cfg_data[7:0];
        ccb_pkg::CFG_FRAME_SELECT:  cfg.frame_select  <= cfg_data[7:0];
        ccb_pkg::CFG_DRAW_X:        cfg.draw_x        <= cfg_data[9:0];
        ccb_pkg::CFG_DRAW_Y:        cfg.draw_y        <= cfg_data[9:0];
        ccb_pkg::CFG_KEY_COLOR:     cfg.key_color     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_next.pixel = pixel_item.pixel_value;
    pos_next.col   = pixel_item.sheet_start ? '0 : column_count;
    pos_next.row   = pixel_item.sheet_start ? '0 : row_count;
    pos_next.frame = pixel_item.sheet_start ? '0 : frame_count;

    col_inc = {1'b0, pos_next.col} + 10'd1;
    row_inc = {1'b0, pos_next.row} + 9'd1;

    column_count_next = col_inc[8:0];
    row_count_next    = pos_next.row;
    frame_count_next  = pos_next.frame;
    if (col_inc >= {1'b0, cfg.sprite_width}) begin
      column_count_next = '0;
      if (row_inc >= {1'b0, cfg.sprite_height}) begin
        row_count_next   = '0;
        frame_count_next = pos_next.frame + 8'd1;
      end else begin
        row_count_next = row_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      frame_count  <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      frame_count  <= frame_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= 1'b0;
    end else if (out_ready) begin
      pos_valid <= accept;
    end else if (accept) begin
      pos_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= pos_next;
    end
  end

  ccb_place #(
    .SURFACE_WIDTH (SURFACE_WIDTH),
    .SURFACE_HEIGHT(SURFACE_HEIGHT)
  ) u_place (
    .cfg  (cfg),
    .pos  (pos),
    .place(place)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_valid <= 1'b0;
    end else if (out_ready) begin
      write_valid <= pos_valid && place.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      write_item.write_address <= place.address;
      write_item.write_value   <= pos.pixel;
    end
  end

endmodule

`default_nettype wire

@@ sv/ccb_checker.sv @@
`default_nettype none

module ccb_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pixel_valid,
  input logic                 pixel_stall,
  input logic                 write_valid,
  input logic                 write_stall,
  input ccb_pkg::write_item_t write_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    write_valid && write_stall |=> write_valid && $stable(write_item))
    else $error("stalled write item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !write_valid)
    else $error("write valid after reset");

  a_no_stall_when_empty: assert property (@(posedge clk)
    !write_valid |-> !pixel_stall)
    else $error("input stalled with empty output");

  // a newly raised write valid comes from a pixel item taken into the position register
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    $rose(write_valid) && !$past(rst) |-> $past(pixel_valid && !pixel_stall, 2))
    else $error("write item without an accepted pixel item");

endmodule

bind clipped_color_key_blit ccb_checker u_ccb_checker (
  .clk        (clk),
  .rst        (rst),
  .pixel_valid(pixel_valid),
  .pixel_stall(pixel_stall),
  .write_valid(write_valid),
  .write_stall(write_stall),
  .write_item (write_item)
);

`default_nettype wire

@@ test/clipped_color_key_blit_tb.sv @@
`timescale 1ns / 1ps

module clipped_color_key_blit_tb;

  localparam int SURF_W = ccb_pkg::DEF_SURFACE_WIDTH;
  localparam int SURF_H = ccb_pkg::DEF_SURFACE_HEIGHT;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [ccb_pkg::CFG_INDEX_W-1:0] UNMAPPED_INDEX_LO = 3'd6;
  localparam logic [ccb_pkg::CFG_INDEX_W-1:0] UNMAPPED_INDEX_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  ccb_pkg::pixel_item_t pixel_item = '0;
  logic write_valid;
  logic write_stall = 1'b0;
  ccb_pkg::write_item_t write_item;
  logic cfg_write_enable = 1'b0;
  logic [ccb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ccb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // blit model state
  ccb_pkg::cfg_t blit_cfg;
  logic [8:0] sheet_col;
  logic [7:0] sheet_row;
  logic [7:0] sheet_frame;
  ccb_pkg::write_item_t surface_writes_due[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  int burst_left = 0;
  logic stall_next;

  clipped_color_key_blit u_dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_item(pixel_item),
    .write_valid(write_valid),
    .write_stall(write_stall),
    .write_item(write_item),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  task automatic reset_blit_model();
    blit_cfg = '0;
    blit_cfg.sprite_width = ccb_pkg::SPRITE_WIDTH_RESET;
    blit_cfg.sprite_height = ccb_pkg::SPRITE_HEIGHT_RESET;
    sheet_col = '0;
    sheet_row = '0;
    sheet_frame = '0;
  endtask

  task automatic apply_reg(input logic [ccb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ccb_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ccb_pkg::CFG_SPRITE_WIDTH: blit_cfg.sprite_width = data[8:0];
      ccb_pkg::CFG_SPRITE_HEIGHT: blit_cfg.sprite_height = data[7:0];
      ccb_pkg::CFG_FRAME_SELECT: blit_cfg.frame_select = data[7:0];
      ccb_pkg::CFG_DRAW_X: blit_cfg.draw_x = data[9:0];
      ccb_pkg::CFG_DRAW_Y: blit_cfg.draw_y = data[9:0];
      ccb_pkg::CFG_KEY_COLOR: blit_cfg.key_color = data[7:0];
      default: ;
    endcase
  endtask

  // place one sheet pixel and queue the surface write it causes, if any
  task automatic place_pixel(input ccb_pkg::pixel_item_t item);
    int sx;
    int sy;
    ccb_pkg::write_item_t hit;
    if (item.sheet_start) begin
      sheet_col = '0;
      sheet_row = '0;
      sheet_frame = '0;
    end
    if (sheet_frame == blit_cfg.frame_select && item.pixel_value != blit_cfg.key_color) begin
      sx = $signed(blit_cfg.draw_x);
      sy = $signed(blit_cfg.draw_y);
      sx = sx + int'(sheet_col);
      sy = sy + int'(sheet_row);
      if (sx >= 0 && sx < SURF_W && sy >= 0 && sy < SURF_H) begin
        hit.write_address = 16'(sy * SURF_W + sx);
        hit.write_value = item.pixel_value;
        surface_writes_due.push_back(hit);
      end
    end
    if (int'(sheet_col) + 1 >= int'(blit_cfg.sprite_width)) begin
      sheet_col = '0;
      if (int'(sheet_row) + 1 >= int'(blit_cfg.sprite_height)) begin
        sheet_row = '0;
        sheet_frame = sheet_frame + 8'd1;
      end else begin
        sheet_row = sheet_row + 8'd1;
      end
    end else begin
      sheet_col = sheet_col + 9'd1;
    end
  endtask

  task automatic send_pixel(input logic [7:0] value, input logic start);
    ccb_pkg::pixel_item_t item;
    int gap;
    item.pixel_value = value;
    item.sheet_start = start;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_item <= item;
    do @(posedge clk); while (pixel_stall);
    place_pixel(item);
  endtask

  task automatic drain_writes();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (surface_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ccb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic set_blit(input int width, height, frame, dx, dy, key);
    write_reg(ccb_pkg::CFG_SPRITE_WIDTH, 10'(width));
    write_reg(ccb_pkg::CFG_SPRITE_HEIGHT, 10'(height));
    write_reg(ccb_pkg::CFG_FRAME_SELECT, 10'(frame));
    write_reg(ccb_pkg::CFG_DRAW_X, 10'(dx));
    write_reg(ccb_pkg::CFG_DRAW_Y, 10'(dy));
    write_reg(ccb_pkg::CFG_KEY_COLOR, 10'(key));
  endtask

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(0, 4) == 0) return blit_cfg.key_color;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_sheet(input int count, input bit from_start);
    for (int i = 0; i < count; i++)
      send_pixel(pick_pixel(), (i == 0 && from_start) || $urandom_range(0, 49) == 0);
  endtask

  task automatic pick_random_setup();
    int width;
    int height;
    int frame;
    int dx;
    int dy;
    case ($urandom_range(0, 9))
      0: width = 0;
      1: width = 511;
      2: width = 320;
      3: width = $urandom_range(0, 1023);
      default: width = $urandom_range(1, 24);
    endcase
    case ($urandom_range(0, 9))
      0: height = 0;
      1: height = 255;
      2: height = 200;
      3: height = $urandom_range(0, 1023);
      default: height = $urandom_range(1, 12);
    endcase
    frame = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 1);
    case ($urandom_range(0, 7))
      0: dx = -512;
      1: dx = 511;
      2: dx = $urandom_range(0, 1023);
      default: dx = $urandom_range(0, 339) - 20;
    endcase
    case ($urandom_range(0, 7))
      0: dy = -512;
      1: dy = 511;
      2: dy = $urandom_range(0, 1023);
      default: dy = $urandom_range(0, 219) - 20;
    endcase
    set_blit(width, height, frame, dx, dy, $urandom_range(0, 1023));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? UNMAPPED_INDEX_HI : UNMAPPED_INDEX_LO,
                10'($urandom_range(0, 1023)));
  endtask

  task automatic test_reset_defaults();
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h80, 1'b0);
  endtask

  task automatic test_surface_corners();
    drain_writes();
    set_blit(3, 2, 0, SURF_W - 2, SURF_H - 2, 255);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFE, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
  endtask

  task automatic test_negative_origin();
    drain_writes();
    set_blit(2, 2, 0, -1, -1, 0);
    for (int i = 0; i < 4; i++) send_pixel(8'h11 + 8'(i), i == 0);
    drain_writes();
    set_blit(2, 2, 0, 511, -512, 0);
    send_pixel(8'h22, 1'b1);
    send_pixel(8'h33, 1'b0);
  endtask

  // zero width and height make every item end a frame
  task automatic test_frame_select_and_degenerate();
    drain_writes();
    set_blit(0, 0, 2, 40, 30, 255);
    write_reg(UNMAPPED_INDEX_LO, 10'h3FF);
    write_reg(UNMAPPED_INDEX_HI, 10'h155);
    send_pixel(8'h07, 1'b1);
    send_pixel(8'h08, 1'b0);
    send_pixel(8'h09, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h0A, 1'b0);
    send_pixel(8'hFF, 1'b0);
  endtask

  task automatic test_backpressure();
    drain_writes();
    set_blit(8, 8, 0, 100, 50, 0);
    calm = 1'b1;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(1, 255)), i == 0);
    calm = 1'b0;
    drain_writes();
  endtask

  // one pixel per frame, no restart, so the frame counter passes 255
  task automatic test_frame_wrap();
    drain_writes();
    set_blit(1, 1, 0, 5, 5, $urandom_range(0, 255));
    for (int i = 0; i < 260; i++) send_pixel(pick_pixel(), i == 0);
  endtask

  task automatic test_random_sheets();
    for (int p = 0; p < 18; p++) begin
      drain_writes();
      pick_random_setup();
      run_sheet($urandom_range(60, 120), $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic test_steady_stream();
    drain_writes();
    calm = 1'b1;
    set_blit($urandom_range(1, 20), $urandom_range(1, 10), 0,
             $urandom_range(0, 300), $urandom_range(0, 190), $urandom_range(0, 255));
    run_sheet(200, 1'b1);
  endtask

  // receiver: random stall bursts, plus a long hold on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      stall_next = 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(0, 10);
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
    end
    write_stall <= stall_next;
  end

  always @(posedge clk) begin
    ccb_pkg::write_item_t want;
    if (!rst && write_valid && !write_stall) begin
      if (surface_writes_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected write: addr %0d value %0h", write_item.write_address,
                   write_item.write_value);
      end else begin
        want = surface_writes_due.pop_front();
        if (write_item.write_address !== want.write_address ||
            write_item.write_value !== want.write_value) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("write mismatch: expected addr %0d value %0h, got addr %0d value %0h",
                     want.write_address, want.write_value, write_item.write_address,
                     write_item.write_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write_enable || (pixel_valid && !pixel_stall) ||
        (write_valid && !write_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("clipped_color_key_blit verification failed");
      $finish;
    end
  end

  initial begin
    reset_blit_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_surface_corners();
    test_negative_origin();
    test_frame_select_and_degenerate();
    test_backpressure();
    test_frame_wrap();
    test_random_sheets();
    test_steady_stream();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (surface_writes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && surface_writes_due.size() == 0)
      $display("clipped_color_key_blit verification clean");
    else
      $display("clipped_color_key_blit verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ccb_pkg.sv
sv/ccb_place.sv
sv/clipped_color_key_blit.sv
sv/ccb_checker.sv
test/clipped_color_key_blit_tb.sv
